// ===== sv/slce_pkg.sv =====
// Shared definitions for the status LED color engine: command codes, color codes,
// the fixed color tables and the beat record passed between the pipeline stages.
// Depends on nothing; every other file in the block imports it.
package slce_pkg;

   localparam int PixelWidth = 24;
   localparam int LevelWidth = 8;
   localparam int CodeWidth  = 4;
   localparam int CountWidth = 10;
   localparam int HueWidth   = 8;

   // Command codes.
   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_COLOR  = 2'd1;
   localparam logic [1:0] CMD_RGB    = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   // Color codes.
   localparam logic [CodeWidth-1:0] COLOR_OFF     = 4'd0;
   localparam logic [CodeWidth-1:0] COLOR_RED     = 4'd1;
   localparam logic [CodeWidth-1:0] COLOR_GREEN   = 4'd2;
   localparam logic [CodeWidth-1:0] COLOR_BLUE    = 4'd3;
   localparam logic [CodeWidth-1:0] COLOR_YELLOW  = 4'd4;
   localparam logic [CodeWidth-1:0] COLOR_PURPLE  = 4'd5;
   localparam logic [CodeWidth-1:0] COLOR_WHITE   = 4'd6;
   localparam logic [CodeWidth-1:0] COLOR_ORANGE  = 4'd7;
   localparam logic [CodeWidth-1:0] COLOR_RAINBOW = 4'd8;

   localparam logic [CodeWidth-1:0] STATUS_COUNT = 4'd12;
   localparam logic [LevelWidth-1:0] WHEEL_LEVEL = 8'd16;

   typedef logic [LevelWidth-1:0] level_type;
   typedef logic [PixelWidth-1:0] pixel_type;

   // One beat between the command stage and the output register.
   typedef struct packed {
      logic                  wheel;   // pixel comes from the hue wheel
      pixel_type             rgb;     // finished GRB word when not a wheel beat
      logic [HueWidth-1:0]   hue;
   } slce_beat_type;

   function automatic pixel_type pack_grb(input level_type r, input level_type g,
                                          input level_type b);
      return {g, r, b};
   endfunction

   // Device state to color code; only codes below STATUS_COUNT are meaningful.
   function automatic logic [CodeWidth-1:0] status_color(input logic [CodeWidth-1:0] status);
      logic [CodeWidth-1:0] code;
      unique case (status)
         4'd0, 4'd1:         code = COLOR_WHITE;
         4'd2:               code = COLOR_RED;
         4'd3, 4'd4:         code = COLOR_YELLOW;
         4'd5, 4'd6:         code = COLOR_BLUE;
         4'd7:               code = COLOR_GREEN;
         4'd8, 4'd9, 4'd10:  code = COLOR_YELLOW;
         4'd11:              code = COLOR_BLUE;
         default:            code = COLOR_OFF;
      endcase
      return code;
   endfunction

   // Fixed colors for the codes off through orange.
   function automatic pixel_type named_pixel(input logic [2:0] code);
      pixel_type p;
      unique case (code)
         3'd0:    p = pack_grb(8'd0,  8'd0,  8'd0);
         3'd1:    p = pack_grb(8'd32, 8'd0,  8'd0);
         3'd2:    p = pack_grb(8'd0,  8'd32, 8'd0);
         3'd3:    p = pack_grb(8'd0,  8'd0,  8'd32);
         3'd4:    p = pack_grb(8'd24, 8'd24, 8'd0);
         3'd5:    p = pack_grb(8'd24, 8'd0,  8'd24);
         3'd6:    p = pack_grb(8'd8,  8'd8,  8'd8);
         default: p = pack_grb(8'd32, 8'd16, 8'd0);
      endcase
      return p;
   endfunction

   // floor(16 * x / 255). With v = 16x below 255 * 256, v / 255 equals
   // (v + (v >> 8) + 1) >> 8.
   function automatic level_type scale16(input level_type x);
      logic [12:0] v;
      logic [12:0] s;
      v = {1'b0, x, 4'b0000};
      s = v + {9'd0, x[7:4]} + 13'd1;
      return {3'b000, s[12:8]};
   endfunction

endpackage

// ===== sv/slce_cmd.sv =====
// Command stage: holds the enable register, color mode and rainbow counter,
// decodes each accepted command and registers the resulting beat. Uses slce_pkg.
module slce_cmd (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [3:0]                          req_status_code,
   input  logic                                req_web_access,
   input  logic [3:0]                          req_color_code,
   input  logic [7:0]                          req_red,
   input  logic [7:0]                          req_green,
   input  logic [7:0]                          req_blue,
   output logic                                beat_valid,
   input  logic                                beat_ready,
   output slce_pkg::slce_beat_type             beat
);
   import slce_pkg::*;

   logic                    enable_ff;
   logic [CodeWidth-1:0]    mode_ff, mode_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    valid_ff, valid_in;
   slce_beat_type           beat_ff, beat_in;

   logic                    accept;
   logic [CodeWidth-1:0]    mode_next;
   logic [CountWidth-1:0]   count_next;
   logic [CodeWidth-1:0]    status_code;
   logic                    emit;

   assign req_ready = !valid_ff || beat_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_next    = mode_ff;
      count_next   = count_ff;
      emit         = 1'b0;
      beat_in      = '0;
      status_code  = status_color(req_status_code);
      unique case (req_cmd)
         CMD_STATUS: begin
            if (enable_ff) begin
               if (req_web_access) begin
                  mode_next = COLOR_RAINBOW;
               end else if (req_status_code < STATUS_COUNT) begin
                  mode_next   = status_code;
                  emit        = 1'b1;
                  beat_in.rgb = named_pixel(status_code[2:0]);
               end
            end
         end
         CMD_COLOR: begin
            mode_next   = req_color_code;
            emit        = enable_ff && !req_color_code[3];
            beat_in.rgb = named_pixel(req_color_code[2:0]);
         end
         CMD_RGB: begin
            emit        = enable_ff;
            beat_in.rgb = pack_grb(req_red, req_green, req_blue);
         end
         CMD_TICK: begin
            if (enable_ff && mode_ff == COLOR_RAINBOW) begin
               count_next    = count_ff + 10'd1;
               emit          = 1'b1;
               beat_in.wheel = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // The hue is taken after the increment.
      beat_in.hue = count_next[CountWidth-1:CountWidth-HueWidth];

      mode_in  = accept ? mode_next : mode_ff;
      count_in = accept ? count_next : count_ff;
      if (req_ready) begin
         valid_in = accept && emit;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff   <= COLOR_OFF;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         mode_ff  <= mode_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// ===== sv/slce_wheel.sv =====
// Color wheel: turns a registered beat into its GRB pixel word, computing the
// integer HSV wheel color at level 16 for rainbow beats. Uses slce_pkg.
module slce_wheel (
   input  slce_pkg::slce_beat_type   beat,
   output slce_pkg::pixel_type       pixel
);
   import slce_pkg::*;

   logic [16:0]          prod;
   logic [2:0]           region_est;
   logic [2:0]           region;
   logic [8:0]           rem_raw;
   logic [5:0]           rem;
   logic [7:0]           rem6;
   level_type            q;
   level_type            t;
   level_type            r;
   level_type            g;
   level_type            b;
   pixel_type            wheel_pixel;

   always_comb begin
      // hue / 43 by reciprocal 381 / 2^14, off by at most one below.
      prod       = {9'd0, beat.hue} * 17'd381;
      region_est = prod[16:14];
      rem_raw    = {1'b0, beat.hue} - ({6'd0, region_est} * 9'd43);
      if (rem_raw >= 9'd43) begin
         region = region_est + 3'd1;
         rem    = 6'(rem_raw - 9'd43);
      end else begin
         region = region_est;
         rem    = rem_raw[5:0];
      end
      rem6 = {2'd0, rem} * 8'd6;
      q    = scale16(8'd255 - rem6);
      t    = scale16(rem6);

      unique case (region)
         3'd0: begin r = WHEEL_LEVEL; g = t;           b = 8'd0;        end
         3'd1: begin r = q;           g = WHEEL_LEVEL; b = 8'd0;        end
         3'd2: begin r = 8'd0;        g = WHEEL_LEVEL; b = t;           end
         3'd3: begin r = 8'd0;        g = q;           b = WHEEL_LEVEL; end
         3'd4: begin r = t;           g = 8'd0;        b = WHEEL_LEVEL; end
         default: begin r = WHEEL_LEVEL; g = 8'd0;     b = q;           end
      endcase
      wheel_pixel = pack_grb(r, g, b);
      pixel       = beat.wheel ? wheel_pixel : beat.rgb;
   end

endmodule

// ===== sv/slce_out.sv =====
// Output register for the result channel: holds one finished pixel beat until
// the receiver takes it. Uses slce_pkg for the pixel type.
module slce_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  slce_pkg::pixel_type     in_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output slce_pkg::pixel_type     rsp_pixel_grb
);
   import slce_pkg::*;

   logic        valid_ff, valid_in;
   pixel_type   pixel_ff;

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= in_pixel;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_pixel_grb = pixel_ff;

endmodule

// ===== sv/status_led_color_engine.sv =====
// Status LED color engine top level: command stage, color wheel and output register.
// Depends on slce_pkg, slce_cmd, slce_wheel and slce_out.
//
// Usage: commands arrive on the req_ channel (valid/ready). A status update, named
// color, direct RGB or tick beat yields at most one 24-bit GRB pixel on the rsp_
// channel; commands that select rainbow mode, unknown codes, ticks outside rainbow
// mode and anything sent while disabled produce no pixel. csr_wr_en writes the
// enable bit from csr_wr_data at once; write it only while the block is idle.
// Path: each pixel is held first in the command register, then in the output register;
// the wheel math sits between them.
// Throughput: one command per cycle, sustained, as long as rsp_ready stays high.
// When the receiver stalls, the output register holds its beat and the command
// register fills behind it; req_ready drops only when both are occupied.
// Reset clears the enable bit, selects color mode off, zeroes the rainbow
// counter and empties both pipeline registers.
module status_led_color_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic [3:0]              req_status_code,
   input  logic                    req_web_access,
   input  logic [3:0]              req_color_code,
   input  logic [7:0]              req_red,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [23:0]             rsp_pixel_grb
);
   import slce_pkg::*;

   logic            beat_valid;
   logic            beat_ready;
   slce_beat_type   beat;
   pixel_type       beat_pixel;

   slce_cmd u_cmd (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_status_code (req_status_code),
      .req_web_access  (req_web_access),
      .req_color_code  (req_color_code),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .beat_valid      (beat_valid),
      .beat_ready      (beat_ready),
      .beat            (beat)
   );

   slce_wheel u_wheel (
      .beat  (beat),
      .pixel (beat_pixel)
   );

   slce_out u_out (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (beat_valid),
      .in_ready      (beat_ready),
      .in_pixel      (beat_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_grb (rsp_pixel_grb)
   );

endmodule

// ===== verif/tb_status_led_color_engine.sv =====
// Self-checking testbench for the status LED color engine: a directed table, then random
// rainbow runs and noise, with both channels idling at random. Depends on slce_pkg and the
// status_led_color_engine RTL; results are checked against a predictor kept in this file.
`timescale 1ns / 100ps

module tb_status_led_color_engine;
   import slce_pkg::*;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [3:0]           status;
      logic                 web;
      logic [CodeWidth-1:0] color;
      level_type            red;
      level_type            green;
      level_type            blue;
   } led_cmd_type;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_SILENT, CHECK_PIXEL} row_check_type;
   typedef enum logic {STEP_SEND, STEP_ENABLE} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic          enable_value;
      led_cmd_type   command;
      row_check_type check;
      pixel_type     pixel;
   } dir_step_type;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic            csr_wr_data;
   logic            req_valid;
   logic            req_ready;
   logic [1:0]      req_cmd;
   logic [3:0]      req_status_code;
   logic            req_web_access;
   logic [3:0]      req_color_code;
   logic [7:0]      req_red;
   logic [7:0]      req_green;
   logic [7:0]      req_blue;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [23:0]     rsp_pixel_grb;

   // Predictor state, updated when a command beat is accepted.
   logic                 enable_model;
   logic [CodeWidth-1:0] mode_model;
   logic [9:0]           rainbow_count;

   pixel_type expected_pixels[$];
   pixel_type oldest_pixel;
   int        failures;
   logic      tx_calm;
   logic      rx_calm;

   status_led_color_engine dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_status_code (req_status_code),
      .req_web_access  (req_web_access),
      .req_color_code  (req_color_code),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_grb   (rsp_pixel_grb)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [CodeWidth-1:0] state_to_color(input logic [3:0] state);
      logic [CodeWidth-1:0] code;
      case (state)
         4'd0, 4'd1:        code = COLOR_WHITE;
         4'd2:              code = COLOR_RED;
         4'd3, 4'd4:        code = COLOR_YELLOW;
         4'd5, 4'd6, 4'd11: code = COLOR_BLUE;
         4'd7:              code = COLOR_GREEN;
         default:           code = COLOR_YELLOW;
      endcase
      return code;
   endfunction

   function automatic pixel_type fixed_color(input logic [CodeWidth-1:0] code);
      level_type r, g, b;
      case (code)
         COLOR_RED:    begin r = 8'd32; g = 8'd0;  b = 8'd0;  end
         COLOR_GREEN:  begin r = 8'd0;  g = 8'd32; b = 8'd0;  end
         COLOR_BLUE:   begin r = 8'd0;  g = 8'd0;  b = 8'd32; end
         COLOR_YELLOW: begin r = 8'd24; g = 8'd24; b = 8'd0;  end
         COLOR_PURPLE: begin r = 8'd24; g = 8'd0;  b = 8'd24; end
         COLOR_WHITE:  begin r = 8'd8;  g = 8'd8;  b = 8'd8;  end
         COLOR_ORANGE: begin r = 8'd32; g = 8'd16; b = 8'd0;  end
         default:      begin r = 8'd0;  g = 8'd0;  b = 8'd0;  end
      endcase
      return {g, r, b};
   endfunction

   // Six hue sectors of 43 steps (last 41); falling and rising edges scale to level 16.
   function automatic pixel_type wheel_color(input logic [7:0] hue);
      int sector, frac, fall, rise, level;
      level_type r, g, b;
      level  = WHEEL_LEVEL;
      sector = hue / 43;
      frac   = (hue - sector * 43) * 6;
      fall   = (level * (255 - frac)) / 255;
      rise   = (level * frac) / 255;
      case (sector)
         0:       begin r = 8'(level); g = 8'(rise);  b = 8'd0;      end
         1:       begin r = 8'(fall);  g = 8'(level); b = 8'd0;      end
         2:       begin r = 8'd0;      g = 8'(level); b = 8'(rise);  end
         3:       begin r = 8'd0;      g = 8'(fall);  b = 8'(level); end
         4:       begin r = 8'(rise);  g = 8'd0;      b = 8'(level); end
         default: begin r = 8'(level); g = 8'd0;      b = 8'(fall);  end
      endcase
      return {g, r, b};
   endfunction

   task automatic predict_pixel(input led_cmd_type c, output logic emits, output pixel_type px);
      logic                 choose;
      logic [CodeWidth-1:0] pick;
      emits  = 1'b0;
      px     = '0;
      choose = 1'b0;
      pick   = COLOR_OFF;
      case (c.cmd)
         CMD_STATUS: begin
            if (enable_model && c.web) begin
               choose = 1'b1;
               pick   = COLOR_RAINBOW;
            end else if (enable_model && c.status < STATUS_COUNT) begin
               choose = 1'b1;
               pick   = state_to_color(c.status);
            end
         end
         CMD_COLOR: begin
            // The mode is stored even while disabled.
            choose = 1'b1;
            pick   = c.color;
         end
         CMD_RGB: begin
            if (enable_model) begin
               emits = 1'b1;
               px    = {c.green, c.red, c.blue};
            end
         end
         default: begin
            if (enable_model && mode_model == COLOR_RAINBOW) begin
               rainbow_count = rainbow_count + 10'd1;
               emits         = 1'b1;
               px            = wheel_color(rainbow_count[9:2]);
            end
         end
      endcase
      if (choose) begin
         mode_model = pick;
         if (enable_model && pick <= COLOR_ORANGE) begin
            emits = 1'b1;
            px    = fixed_color(pick);
         end
      end
   endtask

   function automatic led_cmd_type random_command();
      led_cmd_type c;
      c.cmd    = 2'($urandom_range(0, 3));
      c.status = 4'($urandom_range(0, 15));
      c.web    = 1'($urandom_range(0, 1));
      c.color  = 4'($urandom_range(0, 15));
      c.red    = 8'($urandom_range(0, 255));
      c.green  = 8'($urandom_range(0, 255));
      c.blue   = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic dir_step_type row(input logic [1:0] cmd, input int status,
                                        input int web, input logic [CodeWidth-1:0] color,
                                        input int r, input int g,
                                        input int b, input row_check_type check,
                                        input int px);
      dir_step_type s;
      s.kind           = STEP_SEND;
      s.enable_value   = 1'b0;
      s.command.cmd    = cmd;
      s.command.status = 4'(status);
      s.command.web    = 1'(web);
      s.command.color  = color;
      s.command.red    = 8'(r);
      s.command.green  = 8'(g);
      s.command.blue   = 8'(b);
      s.check          = check;
      s.pixel          = 24'(px);
      return s;
   endfunction

   function automatic dir_step_type enable_row(input logic value);
      dir_step_type s;
      s              = '0;
      s.kind         = STEP_ENABLE;
      s.enable_value = value;
      s.check        = CHECK_SILENT;
      return s;
   endfunction

   // Drives one command beat, then records what it should produce once it is accepted.
   task automatic send_command(input led_cmd_type c, input row_check_type check,
                               input pixel_type typed);
      int        gap;
      logic      emits;
      pixel_type px;
      gap = tx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c.cmd;
      req_status_code <= c.status;
      req_web_access  <= c.web;
      req_color_code  <= c.color;
      req_red         <= c.red;
      req_green       <= c.green;
      req_blue        <= c.blue;
      do @(posedge clock); while (!req_ready);
      predict_pixel(c, emits, px);
      if (check == CHECK_SILENT) begin
         emits = 1'b0;
      end else if (check == CHECK_PIXEL) begin
         emits = 1'b1;
         px    = typed;
      end
      if (emits) begin
         expected_pixels.push_back(px);
      end
   endtask

   // The enable bit is only written once the pipeline has drained.
   task automatic write_enable(input logic value);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      enable_model  = value;
   endtask

   // Mostly rainbow runs: an opener that selects the wheel, a string of ticks, then noise.
   task automatic run_random_phase(input logic value, input int items);
      int          left;
      int          run;
      int          noise;
      led_cmd_type c;
      write_enable(value);
      left = items;
      while (left > 0) begin
         tx_calm = ($urandom_range(0, 4) == 0);
         c = random_command();
         if ($urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 1) == 1) begin
               c.cmd   = CMD_COLOR;
               c.color = COLOR_RAINBOW;
            end else begin
               c.cmd = CMD_STATUS;
               c.web = 1'b1;
            end
         end
         send_command(c, CHECK_MODEL, '0);
         left--;
         run = $urandom_range(0, 40);
         repeat (run) begin
            c     = random_command();
            c.cmd = CMD_TICK;
            send_command(c, CHECK_MODEL, '0);
            left--;
         end
         noise = $urandom_range(0, 4);
         repeat (noise) begin
            send_command(random_command(), CHECK_MODEL, '0);
            left--;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel beat, expected none, got %06h",
                     $time, rsp_pixel_grb);
            failures++;
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            if (rsp_pixel_grb !== oldest_pixel) begin
               $display("%0t: pixel mismatch, expected %06h, got %06h",
                        $time, oldest_pixel, rsp_pixel_grb);
               failures++;
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      rx_calm    = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 23) == 0) begin
            rx_calm = ~rx_calm;
         end
         stall = rx_calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      dir_step_type steps[$];
      int           drain;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 1'b0;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_STATUS;
      req_status_code <= '0;
      req_web_access  <= 1'b0;
      req_color_code  <= COLOR_OFF;
      req_red         <= '0;
      req_green       <= '0;
      req_blue        <= '0;
      failures      = 0;
      tx_calm       = 1'b0;
      enable_model  = 1'b0;
      mode_model    = COLOR_OFF;
      rainbow_count = '0;

      // While disabled nothing comes out, but a named color still selects the mode.
      steps.push_back(enable_row(1'b0));
      steps.push_back(row(CMD_STATUS, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_RGB, 0, 0, COLOR_OFF, 255, 255, 255, CHECK_SILENT, 0));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_COLOR, 0, 0, COLOR_RAINBOW, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(enable_row(1'b1));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_PIXEL, 24'h001000));
      steps.push_back(row(CMD_RGB, 0, 0, COLOR_OFF, 255, 0, 0, CHECK_PIXEL, 24'h00FF00));
      steps.push_back(row(CMD_RGB, 0, 0, COLOR_OFF, 0, 255, 0, CHECK_PIXEL, 24'hFF0000));
      steps.push_back(row(CMD_RGB, 0, 0, COLOR_OFF, 0, 0, 255, CHECK_PIXEL, 24'h0000FF));
      steps.push_back(row(CMD_RGB, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_PIXEL, 24'h000000));
      steps.push_back(row(CMD_COLOR, 0, 0, COLOR_RED, 0, 0, 0, CHECK_PIXEL, 24'h002000));
      steps.push_back(row(CMD_COLOR, 0, 0, COLOR_ORANGE, 0, 0, 0, CHECK_PIXEL, 24'h102000));
      steps.push_back(row(CMD_COLOR, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_PIXEL, 24'h000000));
      // An unknown color code is stored, so the tick after it stays silent.
      steps.push_back(row(CMD_COLOR, 0, 0, 4'd15, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_STATUS, 15, 0, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_STATUS, 2, 0, COLOR_OFF, 0, 0, 0, CHECK_PIXEL, 24'h002000));
      steps.push_back(row(CMD_STATUS, 11, 0, COLOR_OFF, 0, 0, 0, CHECK_PIXEL, 24'h000020));
      // Web access wins even over an unknown status code.
      steps.push_back(row(CMD_STATUS, 12, 1, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_MODEL, 0));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_MODEL, 0));
      steps.push_back(row(CMD_COLOR, 0, 0, COLOR_WHITE, 0, 0, 0, CHECK_PIXEL, 24'h080808));
      steps.push_back(row(CMD_COLOR, 0, 0, 4'd9, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_STATUS, 0, 1, COLOR_OFF, 0, 0, 0, CHECK_SILENT, 0));
      steps.push_back(row(CMD_TICK, 0, 0, COLOR_OFF, 0, 0, 0, CHECK_MODEL, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_ENABLE) begin
            write_enable(steps[i].enable_value);
         end else begin
            send_command(steps[i].command, steps[i].check, steps[i].pixel);
         end
      end

      run_random_phase(1'b1, 360);
      run_random_phase(1'b0, 100);
      run_random_phase(1'b1, 360);
      run_random_phase(1'b1, 300);
      run_random_phase(1'b0, 80);
      run_random_phase(1'b1, 250);
      req_valid <= 1'b0;

      drain = 0;
      while (expected_pixels.size() != 0 && drain < 400) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d pixel beats missing, oldest expected %06h, got none",
                  $time, expected_pixels.size(), expected_pixels[0]);
         failures++;
      end
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
